[rtl/core/mbe_pkg.sv]
package mbe_pkg;

  localparam int GRID_POINTS_DEF   = 1024;
  localparam int FRACTION_BITS_DEF = 26;

  localparam int INDEX_W     = 10;
  localparam int FIX_W       = 32;
  localparam int STEP_W      = 31;
  localparam int ITER_W      = 12;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int PROD_W      = 64;

  // |z| > 4  <=>  |z|^2 > 2^4
  localparam int BAILOUT_SQ_LOG2 = 4;

  localparam int RING_STAGES = 3;
  localparam int SEQ_W       = $clog2(RING_STAGES) + 1;

  localparam logic signed [FIX_W-1:0]  ORIGIN_REAL_RST = -32'sd150994944;
  localparam logic signed [FIX_W-1:0]  ORIGIN_IMAG_RST = -32'sd100663296;
  localparam logic        [STEP_W-1:0] STEP_REAL_RST   = 31'd201524;
  localparam logic        [STEP_W-1:0] STEP_IMAG_RST   = 31'd201524;
  localparam logic        [ITER_W-1:0] ITER_LIMIT_RST  = 12'd120;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_REAL = 3'd0,
    REG_ORIGIN_IMAG = 3'd1,
    REG_STEP_REAL   = 3'd2,
    REG_STEP_IMAG   = 3'd3,
    REG_ITER_LIMIT  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [INDEX_W-1:0] column;
    logic [INDEX_W-1:0] row;
  } in_word_t;

  typedef struct packed {
    logic [ITER_W-1:0] iteration_count;
    logic              escaped;
  } out_word_t;

  typedef struct packed {
    logic signed [FIX_W-1:0] c_re;
    logic signed [FIX_W-1:0] c_im;
  } coord_t;

  typedef struct packed {
    logic signed [FIX_W-1:0]  origin_real;
    logic signed [FIX_W-1:0]  origin_imag;
    logic        [STEP_W-1:0] step_real;
    logic        [STEP_W-1:0] step_imag;
    logic        [ITER_W-1:0] iter_limit;
  } cfg_t;

  function automatic logic signed [FIX_W-1:0] sat_fix(input logic signed [PROD_W:0] v);
    logic signed [FIX_W-1:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[FIX_W-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/mandelbrot_escape_time.sv]
// Mandelbrot escape-time evaluator. Each input word names a grid point by column and
// row; c = origin + index * step is formed in signed 32-bit fixed point (FRACTION_BITS
// fraction bits, saturating), then z = z*z + c is iterated from zero until |z|^2 > 16
// or the iteration limit is reached. One output word per input word, in input order.
// The products index * step and then the saturated sum c are registered in turn, then
// every iteration is one trip through a three-stage loop (update z, square, bailout
// test). The loop holds three points at once, so it can take a new point before older
// ones are through. Results leave the loop in order, so a quick point may wait for an
// older slow one. Registers are written through cfg_write/cfg_index/cfg_data and
// should only change while no point is in flight.
module mandelbrot_escape_time import mbe_pkg::*; #(
  parameter int GRID_POINTS   = GRID_POINTS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_word_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_word_t              out_data
);

  cfg_t   cfg;
  logic   c_valid;
  logic   c_ready;
  coord_t c;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_real <= ORIGIN_REAL_RST;
      cfg.origin_imag <= ORIGIN_IMAG_RST;
      cfg.step_real   <= STEP_REAL_RST;
      cfg.step_imag   <= STEP_IMAG_RST;
      cfg.iter_limit  <= ITER_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_REAL: cfg.origin_real <= cfg_data[FIX_W-1:0];
        REG_ORIGIN_IMAG: cfg.origin_imag <= cfg_data[FIX_W-1:0];
        REG_STEP_REAL:   cfg.step_real   <= cfg_data[STEP_W-1:0];
        REG_STEP_IMAG:   cfg.step_imag   <= cfg_data[STEP_W-1:0];
        REG_ITER_LIMIT:  cfg.iter_limit  <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_coord #(
    .GRID_POINTS(GRID_POINTS)
  ) u_coord (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_valid(in_valid),
    .in_data (in_data),
    .in_ready(in_ready),
    .c_valid (c_valid),
    .c       (c),
    .c_ready (c_ready)
  );

  mbe_iter_ring #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .iter_limit(cfg.iter_limit),
    .c_valid   (c_valid),
    .c         (c),
    .c_ready   (c_ready),
    .res_valid (out_valid),
    .res       (out_data),
    .res_ready (out_ready)
  );

endmodule

[rtl/core/mbe_coord.sv]
module mbe_coord import mbe_pkg::*; #(
  parameter int GRID_POINTS = GRID_POINTS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  input  in_word_t in_data,
  output logic     in_ready,
  output logic     c_valid,
  output coord_t   c,
  input  logic     c_ready
);

  localparam int MUL_W = INDEX_W + STEP_W;
  localparam logic [INDEX_W-1:0] INDEX_MAX =
    (GRID_POINTS - 1 > 2**INDEX_W - 1) ? INDEX_W'(2**INDEX_W - 1) : INDEX_W'(GRID_POINTS - 1);

  logic             e1_valid;
  logic [MUL_W-1:0] p_re;
  logic [MUL_W-1:0] p_im;

  logic [INDEX_W-1:0]      col_c;
  logic [INDEX_W-1:0]      row_c;
  logic signed [MUL_W+1:0] sum_re;
  logic signed [MUL_W+1:0] sum_im;
  logic                    e2_free;
  logic                    e1_move;

  assign col_c = (in_data.column > INDEX_MAX) ? INDEX_MAX : in_data.column;
  assign row_c = (in_data.row > INDEX_MAX) ? INDEX_MAX : in_data.row;

  assign sum_re = (MUL_W+2)'(cfg.origin_real) + $signed({2'b00, p_re});
  assign sum_im = (MUL_W+2)'(cfg.origin_imag) + $signed({2'b00, p_im});

  assign e2_free  = !c_valid || c_ready;
  assign e1_move  = e1_valid && e2_free;
  assign in_ready = !e1_valid || e1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      c_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        e1_valid <= in_valid;
      end
      if (e2_free) begin
        c_valid <= e1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_re <= MUL_W'(col_c) * MUL_W'(cfg.step_real);
      p_im <= MUL_W'(row_c) * MUL_W'(cfg.step_imag);
    end
    if (e1_move) begin
      c.c_re <= sat_fix((PROD_W+1)'(sum_re));
      c.c_im <= sat_fix((PROD_W+1)'(sum_im));
    end
  end

endmodule

[rtl/core/mbe_iter_ring.sv]
module mbe_iter_ring import mbe_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ITER_W-1:0] iter_limit,
  input  logic              c_valid,
  input  coord_t            c,
  output logic              c_ready,
  output logic              res_valid,
  output out_word_t         res,
  input  logic              res_ready
);

  localparam int BAIL_SHIFT = 2 * FRACTION_BITS + BAILOUT_SQ_LOG2;
  localparam logic [PROD_W-1:0] BAIL_MASK = (PROD_W'(1) << BAIL_SHIFT) - PROD_W'(1);

  typedef struct packed {
    logic                     valid;
    logic                     done;
    logic                     escaped;
    logic [SEQ_W-1:0]         seq;
    logic [ITER_W-1:0]        count;
    coord_t                   c;
    logic signed [FIX_W-1:0]  re;
    logic signed [FIX_W-1:0]  im;
    logic signed [PROD_W-1:0] rr;
    logic signed [PROD_W-1:0] ii;
    logic signed [PROD_W-1:0] ri;
  } ring_tok_t;

  ring_tok_t        tok1;
  ring_tok_t        tok2;
  ring_tok_t        tok3;
  logic [SEQ_W-1:0] in_seq;
  logic [SEQ_W-1:0] out_seq;

  logic                     head_emit;
  logic                     slot_free;
  logic                     insert;
  ring_tok_t                s1_in;
  ring_tok_t                tok1_next;
  ring_tok_t                tok2_next;
  ring_tok_t                tok3_next;
  logic signed [PROD_W-1:0] diff;
  logic signed [PROD_W:0]   re_sum;
  logic signed [PROD_W:0]   im_sum;
  logic [PROD_W-1:0]        total;
  logic [PROD_W-1:0]        hi;
  logic                     escape;
  logic [ITER_W:0]          count_inc;

  assign head_emit = tok3.valid && tok3.done && (tok3.seq == out_seq) &&
                     (!res_valid || res_ready);
  assign slot_free = !tok3.valid || head_emit;
  assign c_ready   = slot_free;
  assign insert    = slot_free && c_valid;

  // loop entry: new point, the word coming round from the last stage, or an empty slot once a result leaves
  always_comb begin
    s1_in = tok3;
    if (insert) begin
      s1_in         = '0;
      s1_in.valid   = 1'b1;
      s1_in.done    = (iter_limit == '0);
      s1_in.seq     = in_seq;
      s1_in.c       = c;
    end else if (head_emit) begin
      s1_in = '0;
    end
  end

  // stage 1: z = z^2 + c from the products of the previous pass
  always_comb begin
    diff      = s1_in.rr - s1_in.ii;
    re_sum    = (PROD_W+1)'(diff >>> FRACTION_BITS) + (PROD_W+1)'(s1_in.c.c_re);
    im_sum    = (PROD_W+1)'(s1_in.ri >>> (FRACTION_BITS - 1)) + (PROD_W+1)'(s1_in.c.c_im);
    tok1_next    = s1_in;
    tok1_next.re = sat_fix(re_sum);
    tok1_next.im = sat_fix(im_sum);
  end

  // stage 2: products of the new z
  always_comb begin
    tok2_next    = tok1;
    tok2_next.rr = PROD_W'(tok1.re) * PROD_W'(tok1.re);
    tok2_next.ii = PROD_W'(tok1.im) * PROD_W'(tok1.im);
    tok2_next.ri = PROD_W'(tok1.re) * PROD_W'(tok1.im);
  end

  // stage 3: bailout test and iteration count
  always_comb begin
    total     = tok2.rr + tok2.ii;
    hi        = total >> BAIL_SHIFT;
    escape    = (hi > PROD_W'(1)) || ((hi == PROD_W'(1)) && ((total & BAIL_MASK) != '0));
    count_inc = {1'b0, tok2.count} + (ITER_W+1)'(1);
    tok3_next = tok2;
    if (tok2.valid && !tok2.done) begin
      if (escape) begin
        tok3_next.done    = 1'b1;
        tok3_next.escaped = 1'b1;
      end else begin
        tok3_next.count = count_inc[ITER_W-1:0];
        tok3_next.done  = (count_inc == {1'b0, iter_limit});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok1.valid <= 1'b0;
      tok2.valid <= 1'b0;
      tok3.valid <= 1'b0;
      in_seq     <= '0;
      out_seq    <= '0;
      res_valid  <= 1'b0;
    end else begin
      tok1 <= tok1_next;
      tok2 <= tok2_next;
      tok3 <= tok3_next;
      if (insert) begin
        in_seq <= in_seq + SEQ_W'(1);
      end
      if (head_emit) begin
        out_seq   <= out_seq + SEQ_W'(1);
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_emit) begin
      res.iteration_count <= tok3.count;
      res.escaped         <= tok3.escaped;
    end
  end

endmodule

[rtl/core/mbe_checker.sv]
module mbe_checker import mbe_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   cfg_write,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input out_word_t              out_data
);

  // two entry stages, the loop, one output register
  localparam int CAPACITY = 2 + RING_STAGES + 1;

  logic [3:0]        pending;
  logic [ITER_W-1:0] limit_shadow;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= '0;
      limit_shadow <= ITER_LIMIT_RST;
    end else begin
      pending <= pending + 4'(in_acc) - 4'(out_acc);
      if (cfg_write && (cfg_index == REG_ITER_LIMIT)) begin
        limit_shadow <= cfg_data[ITER_W-1:0];
      end
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != '0))
    else $error("output word without an outstanding input word");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'(CAPACITY))
    else $error("more words in flight than the pipeline holds");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_data.escaped && (out_data.iteration_count < limit_shadow)) ||
                   (!out_data.escaped && (out_data.iteration_count == limit_shadow))))
    else $error("iteration count inconsistent with limit");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 100ps
module tb;
  import mbe_pkg::*;

  localparam int GRID = GRID_POINTS_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam longint FIX_HI = 64'sd2147483647;
  localparam longint FIX_LO = -64'sd2147483648;
  localparam bit [63:0] ESCAPE_MAG = 64'd1 << (2 * FRAC + BAILOUT_SQ_LOG2);
  localparam logic [CFG_DATA_W-1:0] DEF_RE = -32'sd150994944;
  localparam logic [CFG_DATA_W-1:0] DEF_IM = -32'sd100663296;
  localparam logic [CFG_DATA_W-1:0] DEF_STEP = 32'd201524;
  localparam logic [CFG_DATA_W-1:0] DEF_ITERS = 32'd120;
  localparam int RANDOM_ITEMS = 500;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 60;

  class escape_board;
    cfg_t      regs;
    out_word_t predicted_escapes[$];
    int        bad_results;

    function new();
      regs.origin_real = DEF_RE;
      regs.origin_imag = DEF_IM;
      regs.step_real   = DEF_STEP[STEP_W-1:0];
      regs.step_imag   = DEF_STEP[STEP_W-1:0];
      regs.iter_limit  = DEF_ITERS[ITER_W-1:0];
      bad_results = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_ORIGIN_REAL: regs.origin_real = value;
        REG_ORIGIN_IMAG: regs.origin_imag = value;
        REG_STEP_REAL:   regs.step_real   = value[STEP_W-1:0];
        REG_STEP_IMAG:   regs.step_imag   = value[STEP_W-1:0];
        REG_ITER_LIMIT:  regs.iter_limit  = value[ITER_W-1:0];
        default: ;
      endcase
    endfunction

    function longint clip_fix(longint v);
      if (v > FIX_HI) return FIX_HI;
      if (v < FIX_LO) return FIX_LO;
      return v;
    endfunction

    function out_word_t predict_escape(in_word_t p);
      longint    col, row, c_re, c_im, re, im, nre, nim;
      bit [63:0] mag;
      out_word_t r;
      col = (p.column > GRID - 1) ? GRID - 1 : p.column;
      row = (p.row > GRID - 1) ? GRID - 1 : p.row;
      c_re = clip_fix(longint'(signed'(regs.origin_real)) + col * longint'(regs.step_real));
      c_im = clip_fix(longint'(signed'(regs.origin_imag)) + row * longint'(regs.step_imag));
      re = 0;
      im = 0;
      r.iteration_count = regs.iter_limit;
      r.escaped = 1'b0;
      for (int i = 0; i < int'(regs.iter_limit) && !r.escaped; i++) begin
        nre = clip_fix(((re * re - im * im) >>> FRAC) + c_re);
        nim = clip_fix(((re * im) >>> (FRAC - 1)) + c_im);
        re = nre;
        im = nim;
        mag = re * re + im * im;
        if (mag > ESCAPE_MAG) begin
          r.iteration_count = ITER_W'(i);
          r.escaped = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_point(in_word_t p);
      predicted_escapes.push_back(predict_escape(p));
    endfunction

    task report_mismatch(string what);
      bad_results++;
      if (bad_results <= 50) $display("mismatch at %0t: %s", $time, what);
    endtask

    task check_escape(out_word_t got);
      out_word_t want;
      if (predicted_escapes.size() == 0) begin
        report_mismatch($sformatf("unpredicted word: count %0d escaped %0b",
                                  got.iteration_count, got.escaped));
      end else begin
        want = predicted_escapes.pop_front();
        if (got.iteration_count !== want.iteration_count)
          report_mismatch($sformatf("iteration_count %0d, predicted %0d",
                                    got.iteration_count, want.iteration_count));
        if (got.escaped !== want.escaped)
          report_mismatch($sformatf("escaped %0b, predicted %0b", got.escaped, want.escaped));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  in_word_t               in_data;
  logic                   out_valid;
  logic                   out_ready;
  out_word_t              out_data;

  escape_board board;
  int          hold_request = 0;
  bit          calm = 1'b0;
  int          cycles = 0;

  mandelbrot_escape_time u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic in_word_t point(int unsigned c, int unsigned r);
    in_word_t w;
    w.column = INDEX_W'(c);
    w.row    = INDEX_W'(r);
    return w;
  endfunction

  task automatic put_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    board.write_reg(idx, value);
    @(posedge clk);
  endtask

  // all five registers, then a stray write to an unused index
  task automatic program_regs(logic [CFG_DATA_W-1:0] o_re, logic [CFG_DATA_W-1:0] o_im,
                              logic [CFG_DATA_W-1:0] s_re, logic [CFG_DATA_W-1:0] s_im,
                              logic [CFG_DATA_W-1:0] iters);
    put_reg(REG_ORIGIN_REAL, o_re);
    put_reg(REG_ORIGIN_IMAG, o_im);
    put_reg(REG_STEP_REAL, s_re);
    put_reg(REG_STEP_IMAG, s_im);
    put_reg(REG_ITER_LIMIT, iters);
    put_reg(CFG_INDEX_W'(REG_ITER_LIMIT + $urandom_range(1, 3)), $urandom);
    cfg_write <= 1'b0;
  endtask

  task automatic send_point(in_word_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_point(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.predicted_escapes.size() != 0) @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int hold_left;
    int ready_gap;
    hold_left = 0;
    ready_gap = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) board.check_escape(out_data);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) ready_gap = pick_gap();
      end
    end
  end

  initial begin
    int random_sent;
    int phase;
    int kind;
    int n;
    logic [CFG_DATA_W-1:0] o_re, o_im, s_re, s_im, iters;
    board = new();
    rst       <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: grid corners, bit patterns, a point inside the set
    send_point(point(0, 0));
    send_point(point(GRID - 1, GRID - 1));
    send_point(point(0, GRID - 1));
    send_point(point(GRID - 1, 0));
    send_point(point(750, 500));
    send_point(point(341, 682));
    send_point(point(682, 341));
    send_point(point(512, 0));
    drain_results();

    // zero iteration limit
    program_regs(DEF_RE, DEF_IM, DEF_STEP, DEF_STEP, 32'd0);
    send_point(point(0, 0));
    send_point(point(750, 500));
    drain_results();

    program_regs(DEF_RE, DEF_IM, DEF_STEP, DEF_STEP, 32'd1);
    send_point(point(0, 0));
    send_point(point(750, 500));
    send_point(point(GRID - 1, GRID - 1));
    drain_results();

    // full limit, two interior points
    program_regs(DEF_RE, DEF_IM, DEF_STEP, DEF_STEP, 32'd4095);
    send_point(point(750, 500));
    send_point(point(0, 0));
    send_point(point(600, 500));
    drain_results();

    // c = -2 bounces on the real axis and never escapes
    program_regs(-32'sd134217728, 32'd0, 32'd0, 32'd0, 32'd2048);
    send_point(point(0, 0));
    send_point(point(GRID - 1, GRID - 1));
    drain_results();

    // coordinate saturation at both ends
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd3);
    send_point(point(GRID - 1, GRID - 1));
    send_point(point(0, 0));
    send_point(point(1, 0));
    drain_results();

    program_regs(32'h8000_0000, 32'd0, 32'd0, 32'h8000_0001, 32'hFFFF_F555);
    send_point(point(0, 0));
    send_point(point(GRID - 1, GRID - 1));
    drain_results();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      kind = (phase == 3) ? 0 : $urandom_range(1, 8);
      if (kind == 0) begin
        o_re  = $urandom;
        o_im  = $urandom;
        s_re  = $urandom;
        s_im  = $urandom;
        iters = $urandom_range(0, 4095);
        n = 3;
      end else begin
        o_re  = $urandom_range(0, 3 << 26) - (5 << 25);
        o_im  = $urandom_range(0, 3 << 26) - (3 << 25);
        s_re  = $urandom_range(0, 1 << 18) | ($urandom_range(0, 1) << 31);
        s_im  = $urandom_range(0, 1 << 18) | ($urandom_range(0, 1) << 31);
        iters = (phase == 0) ? $urandom_range(4, 16) : $urandom_range(1, 160);
        n = 50;
      end
      program_regs(o_re, o_im, s_re, s_im, iters);
      calm = (phase % 4 == 1);
      // output held off long enough for the loop to back up into the input
      if (phase == 0) hold_request = 2500;
      for (int k = 0; k < n; k++) begin
        send_point(point($urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1)));
        random_sent++;
      end
      drain_results();
      calm = 1'b0;
      phase++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.bad_results == 0 && board.predicted_escapes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
